/* design/rur_pkg.sv */
// shared types, constants and helpers for the reliable update retransmitter
// no dependencies
package rur_pkg;

  localparam int ITEMS = 32;
  localparam int ID_W = 5;
  localparam int SEQ_W = 8;
  localparam int TIME_W = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int CFG_ADDR_W = 4;

  localparam logic [5:0] WIDGET_COUNT_RST = 6'd0;
  localparam logic [31:0] INPUT_MASK_RST = 32'd0;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [7:0] MAX_RETRIES_RST = 8'd3;

  typedef enum logic [1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_PUSH_VALUE = 2'd1,
    FUNC_PUSH_META  = 2'd2,
    FUNC_ACK        = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_SET_INPUT = 2'd0,
    KIND_VALUE     = 2'd1,
    KIND_FULL_SYNC = 2'd2,
    KIND_META      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_WIDGET_COUNT = 2'd0,
    REG_INPUT_MASK   = 2'd1,
    REG_TIMEOUT      = 2'd2,
    REG_MAX_RETRIES  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  item_id;
    logic [7:0]  ack_seq;
    logic [31:0] now_ms;
    logic        link_up;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] out_id;
    logic [7:0] out_seq;
    logic [7:0] attempt;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic              tick;
    logic              push;
    logic              ack;
    logic [ID_W-1:0]   push_id;
    logic [SEQ_W-1:0]  ack_seq;
    logic [TIME_W-1:0] now;
  } chan_op_t;

  typedef struct packed {
    logic             send;
    logic             drop;
    logic [ID_W-1:0]  id;
    logic [SEQ_W-1:0] seq;
    logic [7:0]       attempt;
  } chan_res_t;

  function automatic logic [ID_W-1:0] lowest_set(logic [ITEMS-1:0] v);
    logic [ID_W-1:0] idx;
    idx = '0;
    for (int i = ITEMS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = ID_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* design/rur_ifs.sv */
// valid/ready stream interfaces for the input and result channels
// depends on rur_pkg
interface rur_in_if;
  logic              valid;
  logic              ready;
  rur_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport mon (input valid, input data, input ready);
endinterface

interface rur_out_if;
  logic               valid;
  logic               ready;
  rur_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport mon (input valid, input data, input ready);
endinterface

/* design/reliable_update_retransmitter.sv */
// top level: input register, value and meta retransmit channels, result queue
// and apb configuration registers; depends on rur_pkg, rur_ifs, rur_chan
//
// in_ch carries words of four kinds: a tick (with the time and link state),
// a push of a value or meta update for an item id, or an acknowledgement.
// A tick while the link is up gives zero, one or two result words on out_ch:
// the value channel's send or drop first, then the meta channel's send; the
// final word of a tick has last set. Pushes and acks give no result.
// An accepted word is held in the input register until the result queue has
// room; both channels then process it and its results go through the queue.
// One word per cycle is taken while the four-entry result queue keeps room
// for two results; a tick that yields two results every cycle is bounded by
// the single output port, one result per cycle.
// When the receiver stalls, the queue fills and in_ch.ready drops; nothing
// is lost. The head of the queue holds steady on out_ch while stalled.
// Reset (rst_n low at a clock edge) clears both channels, empties the queue
// and loads the register defaults: widget count 0, input mask 0,
// timeout 500 ms, max retries 3. Registers are written over the apb port,
// which the user must do only while the block is idle; the block does not enforce it.
module reliable_update_retransmitter (
  input  logic                               clk,
  input  logic                               rst_n,
  rur_in_if.sink                             in_ch,
  rur_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [rur_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  logic [5:0]  widget_count_r;
  logic [31:0] input_mask_r;
  logic [15:0] timeout_r;
  logic [7:0]  max_retries_r;
  logic        cfg_wr;
  rur_pkg::reg_idx_t cfg_idx;

  rur_pkg::in_word_t item_r;
  logic              item_vld_r;
  logic              proc_fire;
  logic              in_fire;

  rur_pkg::out_word_t                  queue_r [rur_pkg::QUEUE_DEPTH];
  logic [rur_pkg::QPTR_W-1:0]          wr_ptr_r, rd_ptr_r;
  logic [rur_pkg::QPTR_W-1:0]          wr_ptr_p1;
  logic [rur_pkg::QPTR_W:0]            count_r, count_nxt;
  logic [rur_pkg::QPTR_W:0]            count_after_pop;
  logic                                pop;
  logic                                room;

  logic                 id_ok;
  logic                 is_tick;
  rur_pkg::chan_op_t    val_op, meta_op;
  rur_pkg::chan_res_t   val_res, meta_res;
  logic                 val_out, meta_out;
  rur_pkg::out_word_t   val_word, meta_word;
  rur_pkg::out_word_t   slot0, slot1;
  logic                 push0, push1;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx = rur_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widget_count_r <= rur_pkg::WIDGET_COUNT_RST;
      input_mask_r   <= rur_pkg::INPUT_MASK_RST;
      timeout_r      <= rur_pkg::TIMEOUT_RST;
      max_retries_r  <= rur_pkg::MAX_RETRIES_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rur_pkg::REG_WIDGET_COUNT: widget_count_r <= cfg_pwdata[5:0];
        rur_pkg::REG_INPUT_MASK:   input_mask_r   <= cfg_pwdata;
        rur_pkg::REG_TIMEOUT:      timeout_r      <= cfg_pwdata[15:0];
        rur_pkg::REG_MAX_RETRIES:  max_retries_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rur_pkg::REG_WIDGET_COUNT: cfg_prdata = {26'd0, widget_count_r};
      rur_pkg::REG_INPUT_MASK:   cfg_prdata = input_mask_r;
      rur_pkg::REG_TIMEOUT:      cfg_prdata = {16'd0, timeout_r};
      rur_pkg::REG_MAX_RETRIES:  cfg_prdata = {24'd0, max_retries_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  // input register
  assign pop             = out_ch.valid && out_ch.ready;
  assign count_after_pop = count_r - {{rur_pkg::QPTR_W{1'b0}}, pop};
  assign room = count_after_pop <= (rur_pkg::QPTR_W + 1)'(rur_pkg::QUEUE_DEPTH - 2);
  assign proc_fire   = item_vld_r && room;
  assign in_ch.ready = !item_vld_r || proc_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_ch.data;
    end
  end

  // channel operations
  assign id_ok = (item_r.item_id < {2'b00, widget_count_r}) &&
                 (item_r.item_id < 8'(rur_pkg::ITEMS));
  assign is_tick = proc_fire && (item_r.func == rur_pkg::FUNC_TICK) && item_r.link_up;

  always_comb begin
    val_op         = '0;
    val_op.tick    = is_tick;
    val_op.push    = proc_fire && (item_r.func == rur_pkg::FUNC_PUSH_VALUE) && id_ok;
    val_op.ack     = proc_fire && (item_r.func == rur_pkg::FUNC_ACK);
    val_op.push_id = item_r.item_id[rur_pkg::ID_W-1:0];
    val_op.ack_seq = item_r.ack_seq;
    val_op.now     = item_r.now_ms;
    meta_op        = val_op;
    meta_op.push   = proc_fire && (item_r.func == rur_pkg::FUNC_PUSH_META) && id_ok;
  end

  rur_chan u_val_chan (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (val_op),
    .timeout     (timeout_r),
    .max_retries (max_retries_r),
    .res         (val_res)
  );

  rur_chan u_meta_chan (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (meta_op),
    .timeout     (timeout_r),
    .max_retries (max_retries_r),
    .res         (meta_res)
  );

  // result words
  assign val_out  = val_res.send || val_res.drop;
  assign meta_out = meta_res.send;

  always_comb begin
    val_word.out_id  = val_res.id;
    val_word.out_seq = val_res.seq;
    val_word.attempt = val_res.attempt;
    val_word.last    = !meta_out;
    if (val_res.drop) begin
      val_word.kind = rur_pkg::KIND_FULL_SYNC;
    end else if (input_mask_r[val_res.id]) begin
      val_word.kind = rur_pkg::KIND_SET_INPUT;
    end else begin
      val_word.kind = rur_pkg::KIND_VALUE;
    end
    meta_word.kind    = rur_pkg::KIND_META;
    meta_word.out_id  = meta_res.id;
    meta_word.out_seq = meta_res.seq;
    meta_word.attempt = meta_res.attempt;
    meta_word.last    = 1'b1;
  end

  assign push0 = val_out || meta_out;
  assign push1 = val_out && meta_out;
  assign slot0 = val_out ? val_word : meta_word;
  assign slot1 = meta_word;

  // result queue
  assign wr_ptr_p1 = wr_ptr_r + {{(rur_pkg::QPTR_W-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (push0) begin
      queue_r[wr_ptr_r] <= slot0;
    end
    if (push1) begin
      queue_r[wr_ptr_p1] <= slot1;
    end
  end

  assign count_nxt = count_after_pop + {{rur_pkg::QPTR_W{1'b0}}, push0}
                                     + {{rur_pkg::QPTR_W{1'b0}}, push1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + {{(rur_pkg::QPTR_W-1){1'b0}}, push0}
                           + {{(rur_pkg::QPTR_W-1){1'b0}}, push1};
      rd_ptr_r <= rd_ptr_r + {{(rur_pkg::QPTR_W-1){1'b0}}, pop};
      count_r  <= count_nxt;
    end
  end

  assign out_ch.valid = count_r != '0;
  assign out_ch.data  = queue_r[rd_ptr_r];

endmodule

/* design/rur_chan.sv */
// one stop-and-wait retransmit channel: pending map, current id, sequence,
// retry count and send time; depends on rur_pkg
module rur_chan (
  input  logic               clk,
  input  logic               rst_n,
  input  rur_pkg::chan_op_t  op,
  input  logic [15:0]        timeout,
  input  logic [7:0]         max_retries,
  output rur_pkg::chan_res_t res
);

  logic [rur_pkg::ITEMS-1:0]  pend_r, pend_nxt;
  logic [rur_pkg::ID_W-1:0]   cur_r, cur_nxt;
  logic [rur_pkg::SEQ_W-1:0]  seq_r, seq_nxt;
  logic [7:0]                 retry_r, retry_nxt;
  logic [rur_pkg::TIME_W-1:0] sent_r, sent_nxt;
  logic [rur_pkg::TIME_W-1:0] elapsed;
  logic                       due;

  always_comb begin
    pend_nxt  = pend_r;
    cur_nxt   = cur_r;
    seq_nxt   = seq_r;
    retry_nxt = retry_r;
    sent_nxt  = sent_r;
    res       = '0;
    elapsed   = '0;
    due       = 1'b0;

    if (op.push) begin
      pend_nxt[op.push_id] = 1'b1;
    end

    if (op.ack && (pend_r != '0) && (op.ack_seq == seq_r)) begin
      pend_nxt[cur_r] = 1'b0;
      retry_nxt       = '0;
    end

    if (op.tick && (pend_r != '0)) begin
      if (!pend_r[cur_r]) begin
        cur_nxt   = rur_pkg::lowest_set(pend_r);
        seq_nxt   = seq_r + 8'd1;
        retry_nxt = '0;
        sent_nxt  = '0;
      end
      elapsed = op.now - sent_nxt;
      due = (sent_nxt == '0) || (elapsed >= {16'd0, timeout});
      res.id  = cur_nxt;
      res.seq = seq_nxt;
      if (due) begin
        res.attempt = retry_nxt;
        if (retry_nxt >= max_retries) begin
          res.drop          = 1'b1;
          pend_nxt[cur_nxt] = 1'b0;
          retry_nxt         = '0;
        end else begin
          res.send  = 1'b1;
          sent_nxt  = op.now;
          retry_nxt = retry_nxt + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      cur_r   <= '0;
      seq_r   <= '0;
      retry_r <= '0;
      sent_r  <= '0;
    end else begin
      pend_r  <= pend_nxt;
      cur_r   <= cur_nxt;
      seq_r   <= seq_nxt;
      retry_r <= retry_nxt;
      sent_r  <= sent_nxt;
    end
  end

endmodule

/* design/rur_checker.sv */
// port-level checks for the reliable update retransmitter, bound to the top
// depends on rur_pkg and the top level's ports
module rur_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input rur_pkg::out_word_t             out_data,
  input logic                           cfg_pready
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // a meta send is always the final word of its tick
  a_meta_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == rur_pkg::KIND_META) |-> out_data.last)
    else $error("meta word without last");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // the input side is never blocked while the block holds nothing
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!out_valid) && $past(!in_valid) |-> in_ready)
    else $error("input stalled while idle");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind reliable_update_retransmitter rur_checker u_rur_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_data   (out_ch.data),
  .cfg_pready (cfg_pready)
);
